>>> design/saluc_pkg.sv
// ----------------------------------------------------------------------------
// saluc_pkg: shared types and constants for the ALU condition-code block
// Operation codes, controller command and datapath status structs.
// ----------------------------------------------------------------------------
package saluc_pkg;

  typedef enum logic [3:0] {
    OP_AND  = 4'd0,
    OP_OR   = 4'd1,
    OP_XOR  = 4'd2,
    OP_UMUL = 4'd3,
    OP_SMUL = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_UDIV = 4'd7,
    OP_SDIV = 4'd8
  } op_e;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic mul_step; // one multiply partial product
    logic div_step; // one quotient bit
    logic finish;   // form result and flags
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic mul_last;
    logic div_last;
  } status_t;

endpackage

>>> design/saluc_datapath.sv
// ----------------------------------------------------------------------------
// saluc_datapath: operand registers, shared multiply and divide units, flags
// Multiply takes four 32x32 partial products; divide is restoring, one bit a cycle.
// ----------------------------------------------------------------------------
module saluc_datapath
  import saluc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [3:0]  mode_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic        use_carry_i,
  input  logic        carry_in_i,
  input  logic [7:0]  flag_update_mask_i,
  input  logic [7:0]  flag_clear_mask_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  output logic [7:0]  cond_flags_o
);

  logic [3:0]  mode_q;
  logic [63:0] a_q, b_q;
  logic        cin_q;
  logic [7:0]  upd_q, clr_q;
  logic [7:0]  cond_q, cond_d;
  logic [1:0]  mstep_q;
  logic [127:0] acc_q;
  logic [63:0] rem_q, quo_q, dvd_q, mb_q;
  logic        neg_q;
  logic [CNT_W-1:0] dcnt_q;
  logic [63:0] lo_q, hi_q;

  logic [31:0] mx, my;
  logic [63:0] pp;
  logic [65:0] trial;
  logic [64:0] rem_sh;

  always_comb begin
    case (mstep_q)
      2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
      2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
      2'd2:    begin mx = a_q[63:32]; my = b_q[31:0];  end
      default: begin mx = a_q[63:32]; my = b_q[63:32]; end
    endcase
  end
  assign pp = mx * my;

  // keep the remainder's top bit: a divisor near 2^64 leaves a 64-bit remainder
  assign rem_sh = {rem_q, dvd_q[63]};
  assign trial  = {1'b0, rem_sh} - {2'b00, mb_q};

  assign status_o.is_mul   = (mode_q == OP_UMUL) || (mode_q == OP_SMUL);
  assign status_o.is_div   = (mode_q == OP_UDIV) || (mode_q == OP_SDIV);
  assign status_o.mul_last = (mstep_q == 2'd3);
  assign status_o.div_last = (dcnt_q == CNT_W'(DIV_STEPS - 1));

  // final result and flags
  logic [63:0] lo, hi;
  logic        c32, c64, v32, v64;
  logic [7:0]  calc;
  logic [64:0] s65;
  logic [32:0] s33;
  always_comb begin
    lo = '0; hi = '0; c32 = 1'b0; c64 = 1'b0; v32 = 1'b0; v64 = 1'b0;
    s65 = '0; s33 = '0;
    case (mode_q)
      OP_AND: lo = a_q & b_q;
      OP_OR:  lo = a_q | b_q;
      OP_XOR: lo = a_q ^ b_q;
      OP_UMUL: begin lo = acc_q[63:0]; hi = acc_q[127:64]; end
      OP_SMUL: begin
        lo = acc_q[63:0];
        hi = acc_q[127:64] - (a_q[63] ? b_q : 64'd0) - (b_q[63] ? a_q : 64'd0);
      end
      OP_ADD: begin
        s65 = {1'b0, a_q} + {1'b0, b_q} + {64'd0, cin_q};
        lo = s65[63:0];
        hi = {63'd0, s65[64]};
        c64 = s65[64];
        c32 = a_q[32] ^ b_q[32] ^ lo[32];
        v32 = ~(a_q[31] ^ b_q[31]) & (a_q[31] ^ lo[31]);
        v64 = ~(a_q[63] ^ b_q[63]) & (a_q[63] ^ lo[63]);
      end
      OP_SUB: begin
        s65 = {1'b0, a_q} - {1'b0, b_q} - {64'd0, cin_q};
        s33 = {1'b0, a_q[31:0]} - {1'b0, b_q[31:0]} - {32'd0, cin_q};
        lo = s65[63:0];
        hi = {64{s65[64]}};
        c64 = s65[64];
        c32 = s33[32];
        v32 = (a_q[31] ^ b_q[31]) & (a_q[31] ^ lo[31]);
        v64 = (a_q[63] ^ b_q[63]) & (a_q[63] ^ lo[63]);
      end
      OP_UDIV: begin
        if (b_q == 64'd0) begin lo = '1; hi = '1; end
        else lo = quo_q;
        v32 = (hi != 64'd0) || (lo[63:32] != 32'd0);
      end
      OP_SDIV: begin
        if (b_q == 64'd0) begin lo = '1; hi = '1; end
        else if (neg_q) begin
          lo = 64'd0 - quo_q;
          hi = (quo_q != 64'd0) ? '1 : '0;
        end else lo = quo_q;
        if (hi[63]) v32 = (hi != '1) || (lo < 64'hffffffff80000000);
        else        v32 = (hi != '0) || (lo > 64'h7fffffff);
      end
      default: ;
    endcase
    calc = {lo[63], lo == 64'd0, v64, c64, lo[31], lo[31:0] == 32'd0, v32, c32};
    if (mode_q > OP_SDIV) cond_d = cond_q;
    else cond_d = (calc & upd_q) | (cond_q & ~(upd_q | clr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= '0;
    end else if (cmd_i.finish) begin
      cond_q <= cond_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      a_q     <= operand_a_i;
      b_q     <= operand_b_i;
      cin_q   <= use_carry_i & carry_in_i;
      upd_q   <= flag_update_mask_i;
      clr_q   <= flag_clear_mask_i;
      mstep_q <= 2'd0;
      acc_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dcnt_q  <= '0;
      if (mode_i == OP_SDIV) begin
        dvd_q <= operand_a_i[63] ? 64'd0 - operand_a_i : operand_a_i;
        mb_q  <= operand_b_i[63] ? 64'd0 - operand_b_i : operand_b_i;
        neg_q <= operand_a_i[63] ^ operand_b_i[63];
      end else begin
        dvd_q <= operand_a_i;
        mb_q  <= operand_b_i;
        neg_q <= 1'b0;
      end
    end else begin
      if (cmd_i.mul_step) begin
        case (mstep_q)
          2'd0:    acc_q <= acc_q + {64'd0, pp};
          2'd1,
          2'd2:    acc_q <= acc_q + {32'd0, pp, 32'd0};
          default: acc_q <= acc_q + {pp, 64'd0};
        endcase
        mstep_q <= mstep_q + 2'd1;
      end
      if (cmd_i.div_step) begin
        dvd_q  <= {dvd_q[62:0], 1'b0};
        rem_q  <= trial[65] ? rem_sh[63:0] : trial[63:0];
        quo_q  <= {quo_q[62:0], ~trial[65]};
        dcnt_q <= dcnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.finish) begin
      lo_q <= (mode_q > OP_SDIV) ? 64'd0 : lo;
      hi_q <= (mode_q > OP_SDIV) ? 64'd0 : hi;
    end
  end

  assign result_low_o  = lo_q;
  assign result_high_o = hi_q;
  assign cond_flags_o  = cond_q;

endmodule

>>> design/saluc_ctrl.sv
// ----------------------------------------------------------------------------
// saluc_ctrl: sequencer for the ALU condition-code block
// Accepts an item, runs multiply or divide steps, presents the result.
// ----------------------------------------------------------------------------
module saluc_ctrl
  import saluc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN, S_OUT} state_e;
  state_e state_q;
  logic   loaded_q;
  logic   fin_ok;

  // a freshly loaded multiply or divide must run its steps before finishing
  assign fin_ok = !(loaded_q && (status_i.is_mul || status_i.is_div));

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o = '0;
    cmd_o.load     = in_valid_i && in_ready_o;
    cmd_o.mul_step = (state_q == S_MUL);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.finish   = (state_q == S_FIN) && fin_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= 1'b0;
    end else begin
      loaded_q <= cmd_o.load;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_FIN;
        S_FIN: begin
          // the operation kind comes from the registered mode, known in the cycle after a load
          if (!fin_ok) state_q <= status_i.is_mul ? S_MUL : S_DIV;
          else         state_q <= S_OUT;
        end
        S_MUL:  if (status_i.mul_last) state_q <= S_FIN;
        S_DIV:  if (status_i.div_last) state_q <= S_FIN;
        S_OUT: begin
          if (out_ready_i) state_q <= in_valid_i ? S_FIN : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/sparc_alu_condition_codes_top.sv
// ----------------------------------------------------------------------------
// sparc_alu_condition_codes_top: SPARC-style ALU with icc/xcc condition codes
// Logic, add and subtract: S_FIN forms result and flags after the input
// transfer, then S_OUT. Multiply: S_MUL adds four 32x32 partial products.
// Divide: S_DIV, one quotient bit per cycle in the restoring divider.
// One item at a time; a new item is taken in the cycle its predecessor leaves.
// Reset (asynchronous, active low) clears the condition register and the FSM.
// ----------------------------------------------------------------------------
module sparc_alu_condition_codes_top
  import saluc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic        use_carry_i,
  input  logic        carry_in_i,
  input  logic [7:0]  flag_update_mask_i,
  input  logic [7:0]  flag_clear_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  output logic [7:0]  cond_flags_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer: hold the result until transferred, then take the next item
  saluc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .status_i (status), .cmd_o(cmd)
  );

  // datapath: operands, iterative multiply/divide, flag update
  saluc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .mode_i, .operand_a_i, .operand_b_i, .use_carry_i, .carry_in_i,
    .flag_update_mask_i, .flag_clear_mask_i,
    .result_low_o, .result_high_o, .cond_flags_o
  );

endmodule

>>> design/saluc_checker.sv
// ----------------------------------------------------------------------------
// saluc_checker: port-level assertions for the ALU condition-code block
// Bound to the top level.
// ----------------------------------------------------------------------------
module saluc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] cond_flags_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cond_flags_o))
    else $error("result dropped while stalled");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown in cycle after transfer");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

endmodule

bind sparc_alu_condition_codes_top saluc_checker u_chk (.*);
